// ===== hw/rtl/wft_pkg.sv =====
// Shared types and constants for the word frequency table.
// Used by the top level, the port checker and the testbench.
`timescale 1ns / 1ps
package wft_pkg;
    localparam int MAX_LEN     = 8;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = IDX_W + 1;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 16;
    localparam int WORD_W      = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [WORD_W-1:0] phrase;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CMP,
        ST_INSERT,
        ST_DP_RD,
        ST_DP_CHK,
        ST_DP_OUT
    } state_t;
endpackage

// ===== hw/rtl/wft_ram.sv =====
// Generic single-port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

// ===== hw/rtl/word_frequency_table_top.sv =====
// Top level of the word frequency table: phrase builder, lookup sequencer and dump.
// Depends on wft_pkg and wft_ram.
`timescale 1ns / 1ps
// An ordinary character is taken directly in the idle state. A separator that
// closes a non-empty phrase walks the table through the single RAM port and
// one compare unit, reading and comparing each stored entry in turn, then
// bumps the count of the matching entry or inserts the phrase as a new one.
// End of text adds a dump that scans the table once for every length from 1
// to MAX_LEN, and each result waits until it is taken. Entries are filled in
// order, so a fill count marks the used part of the table and no clearing
// pass is needed. The input is stalled while any of this runs.
module word_frequency_table_top
    import wft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        ch,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] word,
    output logic [LEN_W-1:0]  word_length,
    output logic [CNT_W-1:0]  occurrences,
    output logic              entries_lost,
    output logic              last
);
    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  buf_reg, buf_next;
    logic [LEN_W-1:0]   pfill_reg, pfill_next;
    logic               lead_reg, lead_next;
    logic [FILL_W-1:0]  tfill_reg, tfill_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   dlen_reg, dlen_next;
    logic [LEN_W-1:0]   maxlen_reg, maxlen_next;
    logic [IDX_W-1:0]   lastidx_reg, lastidx_next;
    logic               lost_reg, lost_next;
    logic               eot_reg, eot_next;
    logic               ov_reg, ov_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [LEN_W-1:0]   wlen_reg, wlen_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic               olost_reg, olost_next;
    logic               olast_reg, olast_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    entry_t             ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    logic [7:0]         c_up;
    logic               is_blank, is_drop, is_sep;
    logic [7:0]         c_norm;
    logic               dp_adv;
    logic               do_reset;
    logic               hit;
    logic [FILL_W-1:0]  idx_inc;

    wft_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rbits)
    );

    assign ram_rdata = entry_t'(ram_rbits);

    always_comb
    begin
        c_up     = (ch inside {[8'h61:8'h7A]}) ? (ch - 8'h20) : ch;
        is_blank = c_up inside {8'h09, 8'h0A, 8'h20};
        is_drop  = c_up inside {8'h28, 8'h29, 8'h27, 8'h22, 8'h2D};
        is_sep   = c_up inside {8'h2C, 8'h2E, 8'h3B, 8'h3A, 8'h3F, 8'h21};
        c_norm   = is_blank ? 8'h20 : c_up;
    end

    assign hit     = (ram_rdata.len == pfill_reg) && (ram_rdata.phrase == buf_reg);
    assign idx_inc = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        pfill_next   = pfill_reg;
        lead_next    = lead_reg;
        tfill_next   = tfill_reg;
        idx_next     = idx_reg;
        dlen_next    = dlen_reg;
        maxlen_next  = maxlen_reg;
        lastidx_next = lastidx_reg;
        lost_next    = lost_reg;
        eot_next     = eot_reg;
        ov_next      = ov_reg;
        word_next    = word_reg;
        wlen_next    = wlen_reg;
        occ_next     = occ_reg;
        olost_next   = olost_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_addr     = idx_reg;
        ram_wdata    = ram_rdata;
        dp_adv       = 1'b0;
        do_reset     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (end_of_text || is_sep)
                    begin
                        eot_next = end_of_text;
                        idx_next = '0;
                        if (pfill_reg != '0)
                        begin
                            state_next = (tfill_reg == '0) ? ST_INSERT : ST_LK_RD;
                        end
                        else if (end_of_text)
                        begin
                            if (tfill_reg == '0)
                            begin
                                do_reset = 1'b1;
                            end
                            else
                            begin
                                dlen_next  = LEN_W'(1);
                                state_next = ST_DP_RD;
                            end
                        end
                    end
                    else if (!is_drop && !(c_norm == 8'h20 && lead_reg))
                    begin
                        lead_next = 1'b0;
                        if (pfill_reg < LEN_W'(MAX_LEN))
                        begin
                            for (int k = 0; k < MAX_LEN; k++)
                            begin
                                if (pfill_reg == LEN_W'(k))
                                begin
                                    buf_next[WORD_W-1-8*k -: 8] = c_norm;
                                end
                            end
                            pfill_next = pfill_reg + 1'b1;
                        end
                    end
                end
            end
            ST_LK_RD:
            begin
                state_next = ST_LK_CMP;
            end
            ST_LK_CMP:
            begin
                if (hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    if (ram_rdata.cnt != COUNT_MAX)
                    begin
                        ram_wdata.cnt = ram_rdata.cnt + 1'b1;
                    end
                    buf_next   = '0;
                    pfill_next = '0;
                    lead_next  = 1'b1;
                    idx_next   = '0;
                    dlen_next  = LEN_W'(1);
                    state_next = eot_reg ? ST_DP_RD : ST_IDLE;
                end
                else if (idx_inc == tfill_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = ST_LK_RD;
                end
            end
            ST_INSERT:
            begin
                if (tfill_reg == FILL_W'(TABLE_DEPTH))
                begin
                    lost_next = 1'b1;
                end
                else
                begin
                    ram_we           = 1'b1;
                    ram_addr         = tfill_reg[IDX_W-1:0];
                    ram_wdata.phrase = buf_reg;
                    ram_wdata.len    = pfill_reg;
                    ram_wdata.cnt    = CNT_W'(1);
                    tfill_next       = tfill_reg + 1'b1;
                    if (pfill_reg >= maxlen_reg)
                    begin
                        maxlen_next  = pfill_reg;
                        lastidx_next = tfill_reg[IDX_W-1:0];
                    end
                end
                buf_next   = '0;
                pfill_next = '0;
                lead_next  = 1'b1;
                idx_next   = '0;
                dlen_next  = LEN_W'(1);
                state_next = eot_reg ? ST_DP_RD : ST_IDLE;
            end
            ST_DP_RD:
            begin
                state_next = ST_DP_CHK;
            end
            ST_DP_CHK:
            begin
                if (ram_rdata.len == dlen_reg)
                begin
                    ov_next    = 1'b1;
                    word_next  = ram_rdata.phrase;
                    wlen_next  = ram_rdata.len;
                    occ_next   = ram_rdata.cnt;
                    olost_next = lost_reg;
                    olast_next = (dlen_reg == maxlen_reg) && (idx_reg == lastidx_reg);
                    state_next = ST_DP_OUT;
                end
                else
                begin
                    dp_adv = 1'b1;
                end
            end
            ST_DP_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    dp_adv  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (dp_adv)
        begin
            state_next = ST_DP_RD;
            if (idx_inc == tfill_reg)
            begin
                idx_next = '0;
                if (dlen_reg == LEN_W'(MAX_LEN))
                begin
                    do_reset = 1'b1;
                end
                else
                begin
                    dlen_next = dlen_reg + 1'b1;
                end
            end
            else
            begin
                idx_next = idx_inc[IDX_W-1:0];
            end
        end

        if (do_reset)
        begin
            state_next  = ST_IDLE;
            buf_next    = '0;
            pfill_next  = '0;
            lead_next   = 1'b1;
            tfill_next  = '0;
            idx_next    = '0;
            maxlen_next = '0;
            lost_next   = 1'b0;
            eot_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            buf_reg     <= '0;
            pfill_reg   <= '0;
            lead_reg    <= 1'b1;
            tfill_reg   <= '0;
            idx_reg     <= '0;
            dlen_reg    <= '0;
            maxlen_reg  <= '0;
            lastidx_reg <= '0;
            lost_reg    <= 1'b0;
            eot_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            buf_reg     <= buf_next;
            pfill_reg   <= pfill_next;
            lead_reg    <= lead_next;
            tfill_reg   <= tfill_next;
            idx_reg     <= idx_next;
            dlen_reg    <= dlen_next;
            maxlen_reg  <= maxlen_next;
            lastidx_reg <= lastidx_next;
            lost_reg    <= lost_next;
            eot_reg     <= eot_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        wlen_reg  <= wlen_next;
        occ_reg   <= occ_next;
        olost_reg <= olost_next;
        olast_reg <= olast_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = ov_reg;
    assign word         = word_reg;
    assign word_length  = wlen_reg;
    assign occurrences  = occ_reg;
    assign entries_lost = olost_reg;
    assign last         = olast_reg;
endmodule

// ===== hw/rtl/wft_checker.sv =====
// Port-level checker for the word frequency table, bound to the top level.
// Depends on wft_pkg.
`timescale 1ns / 1ps
module wft_checker
    import wft_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [WORD_W-1:0] word,
    input logic [LEN_W-1:0]  word_length,
    input logic [CNT_W-1:0]  occurrences
);
    // A pending result always holds the input off.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (word_length != '0) && (word_length <= LEN_W'(MAX_LEN)))
        else $error("result length out of range");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occurrences != '0))
        else $error("result with zero occurrences");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word))
        else $error("stalled result changed");
endmodule

bind word_frequency_table_top wft_checker u_wft_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word       (word),
    .word_length(word_length),
    .occurrences(occurrences)
);

// ===== tb/tb_word_frequency_table_top.sv =====
// Self-checking testbench for word_frequency_table_top: drives character requests,
// predicts the sorted phrase dump and compares every result field by field.
// Depends on wft_pkg and the word_frequency_table_top RTL.
`timescale 1ns / 1ps
module tb_word_frequency_table_top;
    import wft_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  cnt;
        logic              lost;
        logic              last;
    } dump_entry_t;

    typedef struct {
        logic [7:0]        c;
        logic              eot;
        logic              typed;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } stim_row_t;

    localparam int NUM_ROWS = 26;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        ch;
    logic              end_of_text;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  word_length;
    logic [CNT_W-1:0]  occurrences;
    logic              entries_lost;
    logic              last;

    logic [WORD_W-1:0] phrase_acc;
    int unsigned       phrase_len;
    logic              skip_blank;
    logic [WORD_W-1:0] known_phrase [TABLE_DEPTH];
    int unsigned       known_len [TABLE_DEPTH];
    int unsigned       known_cnt [TABLE_DEPTH];
    logic              table_overflow;

    dump_entry_t expected_entries[$];
    stim_row_t   dir_rows [NUM_ROWS];
    int          errors;
    int          sent;
    int          send_idle_pct;
    int          stall_pct;

    word_frequency_table_top u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .ch(ch), .end_of_text(end_of_text), .out_valid(out_valid),
        .out_stall(out_stall), .word(word), .word_length(word_length),
        .occurrences(occurrences), .entries_lost(entries_lost), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_word_frequency_table_top failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void clear_table();
        phrase_acc = '0;
        phrase_len = 0;
        skip_blank = 1'b1;
        table_overflow = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            known_phrase[i] = '0;
            known_len[i] = 0;
            known_cnt[i] = 0;
        end
    endfunction

    function automatic void tally_phrase();
        int hit;
        hit = -1;
        if (phrase_len != 0)
        begin
            for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
                if (known_len[i] == phrase_len && known_phrase[i] == phrase_acc)
                    hit = i;
            if (hit >= 0)
            begin
                if (known_cnt[hit] < 65535)
                    known_cnt[hit]++;
            end
            else
            begin
                for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
                    if (known_len[i] == 0)
                    begin
                        known_phrase[i] = phrase_acc;
                        known_len[i] = phrase_len;
                        known_cnt[i] = 1;
                        hit = i;
                    end
                if (hit < 0)
                    table_overflow = 1'b1;
            end
        end
        phrase_acc = '0;
        phrase_len = 0;
        skip_blank = 1'b1;
    endfunction

    function automatic void predict_dump(input logic [7:0] c_in, input logic eot);
        logic [7:0]  c;
        dump_entry_t e;
        int          first;
        c = c_in;
        if (!eot)
        begin
            if (c >= "a" && c <= "z")
                c = c - 8'd32;
            if (c == 8'h0A || c == 8'h09)
                c = " ";
            if (c == "(" || c == ")" || c == "'" || c == "\"" || c == "-")
                return;
            if (c == "," || c == "." || c == ";" || c == ":" || c == "?" || c == "!")
            begin
                tally_phrase();
                return;
            end
            if (c == " " && skip_blank)
                return;
            skip_blank = 1'b0;
            if (phrase_len < MAX_LEN)
            begin
                phrase_acc[63 - 8 * phrase_len -: 8] = c;
                phrase_len++;
            end
            return;
        end
        tally_phrase();
        first = expected_entries.size();
        for (int l = 1; l <= MAX_LEN; l++)
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (known_len[i] == l)
                begin
                    e.word = known_phrase[i];
                    e.len = LEN_W'(l);
                    e.cnt = CNT_W'(known_cnt[i]);
                    e.lost = table_overflow;
                    e.last = 1'b0;
                    expected_entries.push_back(e);
                end
        if (expected_entries.size() > first)
            expected_entries[expected_entries.size() - 1].last = 1'b1;
        clear_table();
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        predict_dump(c, eot);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_text(input int phrases, input bit noisy);
        int n;
        for (int p = 0; p < phrases; p++)
        begin
            if ($urandom_range(3) == 0)
                send_char(" ", 1'b0);
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
            begin
                if (noisy && $urandom_range(5) == 0)
                    send_char(8'($urandom_range(255)), 1'b0);
                else if ($urandom_range(7) == 0)
                    send_char(" ", 1'b0);
                else
                    send_char(8'("a" + $urandom_range(2) - 32 * $urandom_range(1)), 1'b0);
            end
            case ($urandom_range(5))
                0: send_char(",", 1'b0);
                1: send_char(".", 1'b0);
                2: send_char(";", 1'b0);
                3: send_char(":", 1'b0);
                4: send_char("?", 1'b0);
                default: send_char("!", 1'b0);
            endcase
        end
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_entries.size() == 0)
                report_mismatch("unexpected result", word, 0);
            else
            begin
                if (word !== expected_entries[0].word)
                    report_mismatch("word", word, expected_entries[0].word);
                if (word_length !== expected_entries[0].len)
                    report_mismatch("word_length", word_length, expected_entries[0].len);
                if (occurrences !== expected_entries[0].cnt)
                    report_mismatch("occurrences", occurrences, expected_entries[0].cnt);
                if (entries_lost !== expected_entries[0].lost)
                    report_mismatch("entries_lost", entries_lost, expected_entries[0].lost);
                if (last !== expected_entries[0].last)
                    report_mismatch("last", last, expected_entries[0].last);
                void'(expected_entries.pop_front());
            end
        end
    end

    initial
    begin
        int base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = '0;
        end_of_text = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        clear_table();

        dir_rows[0]  = '{8'h00, 1'b1, 1'b0, 64'h0, 4'd0};
        dir_rows[1]  = '{"a",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[2]  = '{8'hFF, 1'b1, 1'b1, 64'h4100_0000_0000_0000, 4'd1};
        dir_rows[3]  = '{8'h09, 1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[4]  = '{"(",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[5]  = '{"h",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[6]  = '{"i",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[7]  = '{"-",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[8]  = '{8'h0A, 1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[9]  = '{"z",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[10] = '{".",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[11] = '{"?",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[12] = '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[13] = '{":",   1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[14] = '{8'hFF, 1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[15] = '{"!",   1'b0, 1'b0, 64'h0, 4'd0};
        for (int k = 0; k < 9; k++)
            dir_rows[16 + k] = '{8'("A" + k), 1'b0, 1'b0, 64'h0, 4'd0};
        dir_rows[25] = '{")", 1'b1, 1'b0, 64'h0, 4'd0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            base = expected_entries.size();
            send_char(dir_rows[r].c, dir_rows[r].eot);
            if (dir_rows[r].typed)
            begin
                if (expected_entries.size() <= base)
                    report_mismatch("directed dump missing", 0, 1);
                else if (expected_entries[base].word !== dir_rows[r].word ||
                         expected_entries[base].len !== dir_rows[r].len)
                    report_mismatch("directed dump", expected_entries[base].word,
                                    dir_rows[r].word);
            end
        end
        send_char(";", 1'b0);
        send_char("'", 1'b0);
        send_char("\"", 1'b0);
        send_char(",", 1'b1);
        drain_results();

        // More distinct phrases than the table holds, then a repeat of the first.
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
        begin
            send_char(8'(8'h80 + k), 1'b0);
            send_char(",", 1'b0);
        end
        send_char(8'h80, 1'b0);
        send_char(8'h55, 1'b1);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            while (sent < 100 + 25 * (ph + 1))
                send_text($urandom_range(1, 3), $urandom_range(3) == 0);
            drain_results();
        end

        in_valid <= 1'b0;
        repeat (600) @(posedge clk);
        if (errors == 0 && expected_entries.size() == 0)
            $display("tb_word_frequency_table_top passed");
        else
            $display("tb_word_frequency_table_top failed");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/wft_pkg.sv
hw/rtl/wft_ram.sv
hw/rtl/word_frequency_table_top.sv
hw/rtl/wft_checker.sv
tb/tb_word_frequency_table_top.sv
